// ===== rtl/bfwa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded FIFO window average package
// Shared sizes, status codes and sequencer states for the window average.
// ----------------------------------------------------------------------------
package bfwa_pkg;

  localparam int DEPTH    = 5;
  localparam int TAG_BITS = 11;

  localparam int YEAR_W = 16;
  localparam int TAG_W  = 11;
  localparam int STAT_W = 2;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = YEAR_W + CNT_W;
  localparam int BIT_W  = $clog2(SUM_W);

  localparam logic [STAT_W-1:0] STATUS_AVG     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_REMOVED = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } fsm_t;

endpackage

// ===== rtl/bounded_fifo_window_average.sv =====
// ----------------------------------------------------------------------------
// Bounded FIFO window average
// An insert goes through ST_DIV before ST_DONE; a remove goes straight to ST_DONE.
// A new word is taken once the previous one has reached the output register.
// In ST_DIV the bit-serial divider forms one quotient bit a cycle.
// Synchronous reset empties the window and drops any pending result.
// ----------------------------------------------------------------------------
module bounded_fifo_window_average (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          req_type,
  input  logic [bfwa_pkg::YEAR_W-1:0]   year_value,
  input  logic [bfwa_pkg::TAG_W-1:0]    item_tag,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [bfwa_pkg::STAT_W-1:0]   status,
  output logic [bfwa_pkg::YEAR_W-1:0]   mean_year,
  output logic [bfwa_pkg::TAG_W-1:0]    removed_tag,
  output logic [bfwa_pkg::YEAR_W-1:0]   removed_year
);

  localparam int Depth   = bfwa_pkg::DEPTH;
  localparam int TagBits = bfwa_pkg::TAG_BITS;
  localparam int YearW   = bfwa_pkg::YEAR_W;
  localparam int TagW    = bfwa_pkg::TAG_W;
  localparam int CntW    = bfwa_pkg::CNT_W;
  localparam int SlotW   = bfwa_pkg::SLOT_W;
  localparam int SumW    = bfwa_pkg::SUM_W;
  localparam int BitW    = bfwa_pkg::BIT_W;

  logic [YearW-1:0]   year_store [Depth];
  logic [TagBits-1:0] tag_store  [Depth];

  bfwa_pkg::fsm_t state;
  bfwa_pkg::fsm_t state_next;

  logic [SlotW-1:0]          oldest_slot;
  logic [CntW-1:0]           entry_count;
  logic [SumW-1:0]           year_sum;

  logic [SumW-1:0]           div_quo;
  logic [CntW-1:0]           div_rem;
  logic [BitW-1:0]           div_cnt;

  logic [bfwa_pkg::STAT_W-1:0] res_status;
  logic [TagW-1:0]           res_tag;
  logic [YearW-1:0]          res_year;

  logic                      accept;
  logic                      load_out;
  logic                      div_last;
  logic                      full;
  logic                      empty;
  logic [SlotW-1:0]          oldest_inc;
  logic [CntW:0]             slot_sum;
  logic [SlotW-1:0]          wr_slot;
  logic [YearW-1:0]          oldest_year;
  logic [SumW-1:0]           sum_ins;
  logic [CntW:0]             div_shift;
  logic                      div_ge;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      bfwa_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (req_type == 1'b0) ? bfwa_pkg::ST_DIV : bfwa_pkg::ST_DONE;
        end
      end
      bfwa_pkg::ST_DIV: begin
        if (div_last) begin
          state_next = bfwa_pkg::ST_DONE;
        end
      end
      bfwa_pkg::ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = bfwa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfwa_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req_stall = 1'b1;
    load_out  = 1'b0;
    div_last  = 1'b0;
    case (state)
      bfwa_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      bfwa_pkg::ST_DIV: begin
        div_last = (div_cnt == '0);
      end
      bfwa_pkg::ST_DONE: begin
        load_out = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  assign accept = req_valid && !req_stall;

  assign full        = (entry_count == CntW'(Depth));
  assign empty       = (entry_count == '0);
  assign oldest_inc  = (oldest_slot == SlotW'(Depth - 1)) ? '0 : oldest_slot + 1'b1;
  assign slot_sum    = (CntW + 1)'(oldest_slot) + (CntW + 1)'(entry_count);
  assign wr_slot     = full ? oldest_slot :
                       (slot_sum >= (CntW + 1)'(Depth)) ?
                       SlotW'(slot_sum - (CntW + 1)'(Depth)) : SlotW'(slot_sum);
  assign oldest_year = year_store[oldest_slot];
  assign sum_ins     = year_sum - (full ? SumW'(oldest_year) : '0) + SumW'(year_value);

  // One restoring division step: bring down the next dividend bit.
  assign div_shift = {div_rem, div_quo[SumW-1]};
  assign div_ge    = (div_shift >= (CntW + 1)'(entry_count));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bfwa_pkg::ST_IDLE;
      oldest_slot <= '0;
      entry_count <= '0;
      year_sum    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (req_type == 1'b0) begin
          year_sum <= sum_ins;
          if (full) begin
            oldest_slot <= oldest_inc;
          end else begin
            entry_count <= entry_count + 1'b1;
          end
        end else if (!empty) begin
          year_sum    <= year_sum - SumW'(oldest_year);
          oldest_slot <= oldest_inc;
          entry_count <= entry_count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req_type == 1'b0)) begin
      year_store[wr_slot] <= year_value;
      tag_store[wr_slot]  <= TagBits'(item_tag);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      div_quo <= sum_ins;
      div_rem <= '0;
      div_cnt <= BitW'(SumW - 1);
      if (req_type == 1'b0) begin
        res_status <= bfwa_pkg::STATUS_AVG;
        res_tag    <= '0;
        res_year   <= '0;
      end else if (empty) begin
        res_status <= bfwa_pkg::STATUS_EMPTY;
        res_tag    <= '0;
        res_year   <= '0;
      end else begin
        res_status <= bfwa_pkg::STATUS_REMOVED;
        res_tag    <= TagW'(tag_store[oldest_slot]);
        res_year   <= oldest_year;
      end
    end else if (state == bfwa_pkg::ST_DIV) begin
      div_quo <= {div_quo[SumW-2:0], div_ge};
      div_rem <= div_ge ? CntW'(div_shift - (CntW + 1)'(entry_count)) : CntW'(div_shift);
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= res_status;
      mean_year    <= (res_status == bfwa_pkg::STATUS_AVG) ? YearW'(div_quo) : '0;
      removed_tag  <= res_tag;
      removed_year <= res_year;
    end
  end

endmodule

// ===== rtl/bfwa_checker.sv =====
// ----------------------------------------------------------------------------
// Bounded FIFO window average checker
// Port-level checks on result word encoding and on the request and result handshakes.
// ----------------------------------------------------------------------------
module bfwa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [bfwa_pkg::STAT_W-1:0] status,
  input logic [bfwa_pkg::YEAR_W-1:0] mean_year,
  input logic [bfwa_pkg::TAG_W-1:0]  removed_tag,
  input logic [bfwa_pkg::YEAR_W-1:0] removed_year
);

  // A result word carries one of the three defined status codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == bfwa_pkg::STATUS_AVG || status == bfwa_pkg::STATUS_REMOVED ||
                   status == bfwa_pkg::STATUS_EMPTY))
    else $error("undefined status code");

  // Only an average word carries a mean.
  a_mean_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != bfwa_pkg::STATUS_AVG) |-> (mean_year == '0))
    else $error("mean set on a non-average word");

  // Only a removal word carries the removed entry.
  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != bfwa_pkg::STATUS_REMOVED) |->
      (removed_tag == '0 && removed_year == '0))
    else $error("removed entry set on a non-removal word");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while busy");

  // A stalled result word holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) && $stable(mean_year) &&
                                  $stable(removed_tag) && $stable(removed_year)))
    else $error("stalled result word changed");

endmodule

bind bounded_fifo_window_average bfwa_checker u_bfwa_checker (.*);

// ===== bench/bfwa_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Window average bench package
// Request kinds that the stimulus and the checker of the window average
// bench share.
// ----------------------------------------------------------------------------
package bfwa_tb_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

endpackage

// ===== bench/bfwa_window_checker.sv =====
// ----------------------------------------------------------------------------
// Window average checker
// Watches both channels of the window average. It keeps its own copy of the
// window and of the running year sum. From these it works out the word that
// each accepted request must produce, and it compares every returned word,
// field by field, with the oldest word still owed.
// ----------------------------------------------------------------------------
module bfwa_window_checker
  import bfwa_pkg::*;
  import bfwa_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic              req_type,
  input  logic [YEAR_W-1:0] year_value,
  input  logic [TAG_W-1:0]  item_tag,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  logic [STAT_W-1:0] status,
  input  logic [YEAR_W-1:0] mean_year,
  input  logic [TAG_W-1:0]  removed_tag,
  input  logic [YEAR_W-1:0] removed_year,
  output int                fail_count,
  output int                words_pending,
  output int                words_checked,
  output int                insert_count,
  output int                evict_count,
  output int                remove_count,
  output int                empty_count
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [YEAR_W-1:0] mean_year;
    logic [TAG_W-1:0]  removed_tag;
    logic [YEAR_W-1:0] removed_year;
  } window_word_t;

  logic [YEAR_W-1:0] win_year [DEPTH];
  logic [TAG_W-1:0]  win_tag  [DEPTH];
  int                win_head;
  int                win_count;
  logic [SUM_W-1:0]  win_sum;
  window_word_t      owed_words [$];

  function automatic window_word_t pop_oldest_entry();
    window_word_t w;
    w = '0;
    w.status       = STATUS_REMOVED;
    w.removed_tag  = win_tag[win_head];
    w.removed_year = win_year[win_head];
    win_sum   = win_sum - win_year[win_head];
    win_head  = (win_head + 1) % DEPTH;
    win_count = win_count - 1;
    return w;
  endfunction

  function automatic window_word_t apply_window_request(logic kind,
                                                         logic [YEAR_W-1:0] yr,
                                                         logic [TAG_W-1:0] tg);
    window_word_t w;
    int slot;
    w = '0;
    if (kind == REQ_INSERT) begin
      if (win_count == DEPTH) begin
        void'(pop_oldest_entry());
      end
      slot = (win_head + win_count) % DEPTH;
      win_year[slot] = yr;
      win_tag[slot]  = tg;
      win_sum   = win_sum + yr;
      win_count = win_count + 1;
      w.status    = STATUS_AVG;
      w.mean_year = YEAR_W'(win_sum / win_count);
    end else if (win_count == 0) begin
      w.status = STATUS_EMPTY;
    end else begin
      w = pop_oldest_entry();
    end
    return w;
  endfunction

  function automatic int field_differs(string name, longint unsigned want,
                                       longint unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    window_word_t seen;
    window_word_t want;
    int errs;
    errs = 0;
    if (rst) begin
      win_head  = 0;
      win_count = 0;
      win_sum   = '0;
      owed_words.delete();
      fail_count    <= 0;
      words_checked <= 0;
      insert_count  <= 0;
      evict_count   <= 0;
      remove_count  <= 0;
      empty_count   <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        seen = {status, mean_year, removed_tag, removed_year};
        if (owed_words.size() == 0) begin
          $display("%0t: word returned with none owed, status %0d", $time, seen.status);
          errs = errs + 1;
        end else begin
          want = owed_words.pop_front();
          errs += field_differs("status", want.status, seen.status);
          errs += field_differs("mean_year", want.mean_year, seen.mean_year);
          errs += field_differs("removed_tag", want.removed_tag, seen.removed_tag);
          errs += field_differs("removed_year", want.removed_year, seen.removed_year);
        end
        words_checked <= words_checked + 1;
      end
      if (req_valid && !req_stall) begin
        if (req_type == REQ_INSERT) begin
          insert_count <= insert_count + 1;
          if (win_count == DEPTH) evict_count <= evict_count + 1;
        end else begin
          remove_count <= remove_count + 1;
          if (win_count == 0) empty_count <= empty_count + 1;
        end
        owed_words.push_back(apply_window_request(req_type, year_value, item_tag));
      end
      fail_count <= fail_count + errs;
    end
    words_pending <= owed_words.size();
  end

endmodule

// ===== bench/tb_bounded_fifo_window_average.sv =====
// ----------------------------------------------------------------------------
// Window average testbench
// Drives insert and remove words into the window average in random bursts
// while the result side stalls on shifting patterns. A directed opening
// covers the empty window, extreme years and tags, and eviction on a full
// window; random phases then vary the mix of inserts and removes.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_window_average;
  import bfwa_pkg::*;
  import bfwa_tb_pkg::*;

  localparam int RANDOM_WORDS   = 1175;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              req_valid    = 1'b0;
  logic              req_type     = REQ_INSERT;
  logic [YEAR_W-1:0] year_value   = '0;
  logic [TAG_W-1:0]  item_tag     = '0;
  logic              rsp_stall    = 1'b0;
  logic              req_stall;
  logic              rsp_valid;
  logic [STAT_W-1:0] status;
  logic [YEAR_W-1:0] mean_year;
  logic [TAG_W-1:0]  removed_tag;
  logic [YEAR_W-1:0] removed_year;

  int fail_count;
  int words_pending;
  int words_checked;
  int insert_count;
  int evict_count;
  int remove_count;
  int empty_count;

  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_span  = 0;
  logic [2:0]  stall_phase = '0;
  int          idle_cycles;

  wire word_in  = req_valid && !req_stall;
  wire word_out = rsp_valid && !rsp_stall;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bounded_fifo_window_average dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .year_value   (year_value),
    .item_tag     (item_tag),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .mean_year    (mean_year),
    .removed_tag  (removed_tag),
    .removed_year (removed_year)
  );

  bfwa_window_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .year_value    (year_value),
    .item_tag      (item_tag),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .mean_year     (mean_year),
    .removed_tag   (removed_tag),
    .removed_year  (removed_year),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked),
    .insert_count  (insert_count),
    .evict_count   (evict_count),
    .remove_count  (remove_count),
    .empty_count   (empty_count)
  );

  always @(posedge clk) begin
    stall_phase <= stall_phase + 3'd1;
    if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_span <= $urandom_range(40, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE: begin
        rsp_stall <= 1'b0;
      end
      STALL_LIGHT: begin
        rsp_stall <= ($urandom_range(0, 3) == 0);
      end
      STALL_HEAVY: begin
        rsp_stall <= ($urandom_range(0, 9) < 7);
      end
      default: begin
        rsp_stall <= (stall_phase < 3'd3);
      end
    endcase
  end

  task automatic send_word(logic kind, logic [YEAR_W-1:0] yr, logic [TAG_W-1:0] tg);
    req_valid  <= 1'b1;
    req_type   <= kind;
    year_value <= yr;
    item_tag   <= tg;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic hold_off(int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_window_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  function automatic logic [YEAR_W-1:0] pick_year();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return YEAR_W'($urandom_range(1900, 2100));
      default: return YEAR_W'($urandom);
    endcase
  endfunction

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || word_in || word_out) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
    end
    $display("[bounded_fifo_window_average] ERROR");
    $finish;
  end

  initial begin
    int sent;
    int seg_len;
    int insert_pct;
    int burst_left;
    int gap;
    bit no_gaps;
    sent       = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty window first, then fill with extreme years and tags until the
    // window is full and further inserts evict the oldest entry.
    send_word(REQ_REMOVE, '1, '1);
    send_word(REQ_INSERT, '0, '0);
    send_word(REQ_INSERT, '1, '1);
    send_word(REQ_INSERT, '1, 11'h2AA);
    send_word(REQ_INSERT, '1, 11'h555);
    send_word(REQ_INSERT, '1, 11'h001);
    send_word(REQ_INSERT, '1, 11'h400);
    send_word(REQ_INSERT, 16'd1, 11'h7FE);
    send_word(REQ_INSERT, 16'hAAAA, 11'h0F0);
    repeat (DEPTH) send_word(REQ_REMOVE, '1, '1);
    send_word(REQ_REMOVE, '0, '0);
    send_word(REQ_INSERT, 16'd2024, 11'd1);
    send_word(REQ_INSERT, 16'h5555, 11'h3C3);
    send_word(REQ_REMOVE, '0, '0);
    send_word(REQ_REMOVE, '1, '1);
    send_word(REQ_REMOVE, '0, '1);
    drain_window_results();

    while (sent < RANDOM_WORDS) begin
      seg_len = $urandom_range(20, 120);
      if (seg_len > RANDOM_WORDS - sent) seg_len = RANDOM_WORDS - sent;
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 20;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = no_gaps ? 0 : $urandom_range(0, 12);
          if (gap != 0) hold_off(gap);
        end
        burst_left = burst_left - 1;
        send_word(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE,
                  pick_year(), TAG_W'($urandom));
        sent = sent + 1;
      end
      if ($urandom_range(0, 3) == 0) drain_window_results();
    end

    drain_window_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d inserts, %0d of them evicting the oldest entry, and %0d removes,",
             insert_count, evict_count, remove_count);
    $display("%0d of them on an empty window; %0d result words checked, %0d failures.",
             empty_count, words_checked, fail_count);
    if (fail_count == 0 && words_pending == 0) begin
      $display("[bounded_fifo_window_average] OK");
    end else begin
      $display("[bounded_fifo_window_average] ERROR");
    end
    $finish;
  end

endmodule
